// File: sv/tccs_pkg.sv
// ----------------------------------------------------------------------------
// tccs_pkg
// Shared types and constants of the text console with cursor and scroll.
// ----------------------------------------------------------------------------
package tccs_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  localparam int FUNC_W = 2;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int ADDR_W = 11;
  localparam int CELL_W = ATTR_W + CHAR_W;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

  localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SET   = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd3;

  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;

  typedef struct packed {
    logic load;
    logic exec;
    logic copy;
    logic blank;
    logic res_load;
  } tccs_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              scroll;
    logic              copy_last;
    logic              blank_last;
  } tccs_sts_t;

endpackage

// File: sv/tccs_intf.sv
// ----------------------------------------------------------------------------
// tccs channel interfaces
// Valid/ready channels for command items, result items and attribute writes.
// ----------------------------------------------------------------------------
interface tccs_in_if import tccs_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [CHAR_W-1:0] char_code;
  logic [COL_W-1:0]  new_col;
  logic [ROW_W-1:0]  new_row;
  logic [ADDR_W-1:0] cell_addr;

  modport source (output valid, func, char_code, new_col, new_row, cell_addr,
                  input ready);
  modport sink (input valid, func, char_code, new_col, new_row, cell_addr,
                output ready);
endinterface

interface tccs_out_if import tccs_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [COL_W-1:0]  cursor_col;
  logic [ROW_W-1:0]  cursor_row;
  logic [ADDR_W-1:0] hw_cursor_pos;
  logic [CELL_W-1:0] cell_data;

  modport source (output valid, cursor_col, cursor_row, hw_cursor_pos, cell_data,
                  input ready);
  modport sink (input valid, cursor_col, cursor_row, hw_cursor_pos, cell_data,
                output ready);
endinterface

interface tccs_cfg_if import tccs_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [ATTR_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// File: sv/tccs_dp.sv
// ----------------------------------------------------------------------------
// tccs_dp
// Screen memory, cursor registers, sweep counter and result register.
// ----------------------------------------------------------------------------
module tccs_dp import tccs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  tccs_cmd_t         cmd,
  output tccs_sts_t         sts,
  input  logic [FUNC_W-1:0] in_func,
  input  logic [CHAR_W-1:0] in_char_code,
  input  logic [COL_W-1:0]  in_new_col,
  input  logic [ROW_W-1:0]  in_new_row,
  input  logic [ADDR_W-1:0] in_cell_addr,
  input  logic              attr_we,
  input  logic [ATTR_W-1:0] attr_wdata,
  output logic [COL_W-1:0]  res_col,
  output logic [ROW_W-1:0]  res_row,
  output logic [ADDR_W-1:0] res_hw,
  output logic [CELL_W-1:0] res_data
);

  localparam logic [ADDR_W-1:0] COPY_END  = ADDR_W'(CELLS - COLUMNS);
  localparam logic [ADDR_W-1:0] BLANK_END = ADDR_W'(CELLS - 1);

  logic [CELL_W-1:0] mem [CELLS];

  logic [FUNC_W-1:0] func_r;
  logic [CHAR_W-1:0] char_r;
  logic [COL_W-1:0]  ncol_r;
  logic [ROW_W-1:0]  nrow_r;
  logic [ADDR_W-1:0] addr_r;

  logic [ATTR_W-1:0] attr_r;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [ADDR_W-1:0] hw_r, hw_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic [CELL_W-1:0] rd_data_r;

  logic [COL_W-1:0]  put_col;
  logic [ROW_W:0]    put_row;
  logic              put_wr;
  logic [ROW_W-1:0]  put_row_fin;
  logic [ADDR_W-1:0] put_hw;
  logic [ADDR_W-1:0] cur_idx;
  logic              scroll;
  logic              addr_ok;

  logic              we, re;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [CELL_W-1:0] wdata;

  // latched item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      char_r <= in_char_code;
      ncol_r <= in_new_col;
      nrow_r <= in_new_row;
      addr_r <= in_cell_addr;
    end
  end

  assign cur_idx = ADDR_W'(row_r) * ADDR_W'(COLUMNS) + ADDR_W'(col_r);
  assign addr_ok = addr_r < ADDR_W'(CELLS);

  // put character cursor step
  always_comb begin
    put_col = col_r;
    put_row = {1'b0, row_r};
    put_wr  = 1'b0;
    case (char_r)
      CH_NEWLINE: begin
        put_col = '0;
        put_row = {1'b0, row_r} + 1'b1;
      end
      CH_RETURN: begin
        put_col = '0;
      end
      CH_BACKSPACE: begin
        if (col_r != '0) put_col = col_r - 1'b1;
      end
      default: begin
        put_wr = 1'b1;
        if (col_r == COL_W'(COLUMNS - 1)) begin
          put_col = '0;
          put_row = {1'b0, row_r} + 1'b1;
        end else begin
          put_col = col_r + 1'b1;
        end
      end
    endcase
  end

  assign scroll      = (func_r == FUNC_PUT) && (put_row >= (ROW_W + 1)'(ROWS));
  assign put_row_fin = scroll ? ROW_W'(ROWS - 1) : put_row[ROW_W-1:0];
  assign put_hw      = ADDR_W'(put_row_fin) * ADDR_W'(COLUMNS) + ADDR_W'(put_col);

  assign sts.func       = func_r;
  assign sts.scroll     = scroll;
  assign sts.copy_last  = cnt_r == COPY_END;
  assign sts.blank_last = cnt_r == BLANK_END;

  // cursor update
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    hw_nxt  = hw_r;
    if (cmd.exec) begin
      unique case (func_r)
        FUNC_PUT: begin
          col_nxt = put_col;
          row_nxt = put_row_fin;
          hw_nxt  = put_hw;
        end
        FUNC_CLEAR: begin
          col_nxt = '0;
          row_nxt = '0;
        end
        FUNC_SET: begin
          col_nxt = (ncol_r < COL_W'(COLUMNS)) ? ncol_r : COL_W'(COLUMNS - 1);
          row_nxt = (nrow_r < ROW_W'(ROWS)) ? nrow_r : ROW_W'(ROWS - 1);
        end
        default: begin
        end
      endcase
    end
  end

  // sweep counter
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.exec) begin
      cnt_nxt = '0;
    end else if (cmd.copy) begin
      cnt_nxt = sts.copy_last ? COPY_END : cnt_r + 1'b1;
    end else if (cmd.blank) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  // memory port selection
  always_comb begin
    we    = 1'b0;
    waddr = cnt_r;
    wdata = {attr_r, CHAR_W'(0)};
    re    = 1'b0;
    raddr = addr_r;
    if (cmd.exec && func_r == FUNC_PUT && put_wr) begin
      we    = 1'b1;
      waddr = cur_idx;
      wdata = {attr_r, char_r};
    end else if (cmd.copy && cnt_r != '0) begin
      we    = 1'b1;
      waddr = cnt_r - 1'b1;
      wdata = rd_data_r;
    end else if (cmd.blank) begin
      we    = 1'b1;
    end
    if (cmd.exec && func_r == FUNC_READ && addr_ok) begin
      re = 1'b1;
    end else if (cmd.copy && !sts.copy_last) begin
      re    = 1'b1;
      raddr = cnt_r + ADDR_W'(COLUMNS);
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rd_data_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= ATTR_RESET;
      col_r  <= '0;
      row_r  <= '0;
      hw_r   <= '0;
      cnt_r  <= '0;
    end else begin
      if (attr_we) attr_r <= attr_wdata;
      col_r <= col_nxt;
      row_r <= row_nxt;
      hw_r  <= hw_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_col  <= col_r;
      res_row  <= row_r;
      res_hw   <= hw_r;
      res_data <= (func_r == FUNC_READ && addr_ok) ? rd_data_r : '0;
    end
  end

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r < COL_W'(COLUMNS) && row_r < ROW_W'(ROWS))
    else $error("cursor out of screen");

  a_hw_range: assert property (@(posedge clk) disable iff (!rst_n)
    hw_r < ADDR_W'(CELLS))
    else $error("hardware cursor out of screen");

  a_copy_to_blank: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.copy && sts.copy_last |=> cnt_r == COPY_END)
    else $error("blank sweep does not start at last row");

endmodule

// File: sv/tccs_ctrl.sv
// ----------------------------------------------------------------------------
// tccs_ctrl
// Sequencer for item execution, scroll copy, blank sweeps and result handoff.
// ----------------------------------------------------------------------------
module tccs_ctrl import tccs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output tccs_cmd_t cmd,
  input  tccs_sts_t sts
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EXEC  = 3'd1;
  localparam logic [2:0] ST_COPY  = 3'd2;
  localparam logic [2:0] ST_BLANK = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    in_ready      = 1'b0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        unique case (sts.func)
          FUNC_PUT:   state_nxt = sts.scroll ? ST_COPY : ST_FIN;
          FUNC_CLEAR: state_nxt = ST_BLANK;
          default:    state_nxt = ST_FIN;
        endcase
      end
      ST_COPY: begin
        cmd.copy = 1'b1;
        if (sts.copy_last) state_nxt = ST_BLANK;
      end
      ST_BLANK: begin
        cmd.blank = 1'b1;
        if (sts.blank_last) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.res_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == ST_EXEC)
    else $error("accepted item not executed");

  a_res_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |-> !out_valid_r || out_ready)
    else $error("result overwrites pending item");

  a_copy_blank: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_COPY && sts.copy_last |=> state_r == ST_BLANK)
    else $error("scroll copy not followed by blank line");

endmodule

// File: sv/text_console_cursor_scroll.sv
// ----------------------------------------------------------------------------
// text_console_cursor_scroll
// Text console with screen memory, software and hardware cursor and scroll.
// ----------------------------------------------------------------------------
// put, set cursor and read pass through the exec and fin states to result valid
// scroll adds a row copy through the registered read port, then a blank of the last row
// clear adds a blank sweep over all cells, one cell per cycle
// one item at a time; next item accepted in the cycle after its result is loaded
// reset: cursors to zero, attribute to 0x0F; screen memory undefined until written
module text_console_cursor_scroll import tccs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  tccs_in_if.sink    in_if,
  tccs_out_if.source out_if,
  tccs_cfg_if.sink   cfg_if
);

  tccs_cmd_t cmd;
  tccs_sts_t sts;

  assign cfg_if.ready = 1'b1;

  tccs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  tccs_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_func      (in_if.func),
    .in_char_code (in_if.char_code),
    .in_new_col   (in_if.new_col),
    .in_new_row   (in_if.new_row),
    .in_cell_addr (in_if.cell_addr),
    .attr_we      (cfg_if.valid),
    .attr_wdata   (cfg_if.data),
    .res_col      (out_if.cursor_col),
    .res_row      (out_if.cursor_row),
    .res_hw       (out_if.hw_cursor_pos),
    .res_data     (out_if.cell_data)
  );

endmodule

// File: verif/tccs_console_checker.sv
// ----------------------------------------------------------------------------
// tccs_console_checker
// Watches the command, result and attribute channels of the text console,
// keeps its own copy of the screen, both cursors and the attribute, and
// compares every result item with the report predicted for its command.
// ----------------------------------------------------------------------------
module tccs_console_checker import tccs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  tccs_in_if   in_ch,
  tccs_out_if  out_ch,
  tccs_cfg_if  cfg_ch,
  output int   fail_count,
  output int   pending,
  output int   checked_count,
  output int   scroll_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [ADDR_W-1:0] hw;
    logic [CELL_W-1:0] data;
  } cursor_report_t;

  cursor_report_t    due_reports[$];
  cursor_report_t    got, want;
  logic [CELL_W-1:0] screen [CELLS];
  int unsigned       cur_col, cur_row, hw_pos;
  logic [ATTR_W-1:0] attr;

  function automatic cursor_report_t advance_console(input logic [FUNC_W-1:0] f,
                                                     input logic [CHAR_W-1:0] ch,
                                                     input logic [COL_W-1:0]  c,
                                                     input logic [ROW_W-1:0]  r,
                                                     input logic [ADDR_W-1:0] a);
    cursor_report_t    rep;
    logic [CELL_W-1:0] word;
    word = '0;
    case (f)
      FUNC_PUT: begin
        case (ch)
          CH_NEWLINE: begin
            cur_col = 0;
            cur_row++;
          end
          CH_RETURN:    cur_col = 0;
          CH_BACKSPACE: if (cur_col > 0) cur_col--;
          default: begin
            screen[cur_row * COLUMNS + cur_col] = {attr, ch};
            cur_col++;
            if (cur_col >= COLUMNS) begin
              cur_col = 0;
              cur_row++;
            end
          end
        endcase
        if (cur_row >= ROWS) begin
          for (int k = 0; k < CELLS - COLUMNS; k++) screen[k] = screen[k + COLUMNS];
          for (int k = CELLS - COLUMNS; k < CELLS; k++) screen[k] = {attr, {CHAR_W{1'b0}}};
          cur_row = ROWS - 1;
          scroll_count++;
        end
        hw_pos = cur_row * COLUMNS + cur_col;
      end
      FUNC_CLEAR: begin
        for (int k = 0; k < CELLS; k++) screen[k] = {attr, {CHAR_W{1'b0}}};
        cur_col = 0;
        cur_row = 0;
      end
      FUNC_SET: begin
        cur_col = (c < COLUMNS) ? c : COLUMNS - 1;
        cur_row = (r < ROWS) ? r : ROWS - 1;
      end
      FUNC_READ: if (a < CELLS) word = screen[a];
    endcase
    rep.col  = COL_W'(cur_col);
    rep.row  = ROW_W'(cur_row);
    rep.hw   = ADDR_W'(hw_pos);
    rep.data = word;
    return rep;
  endfunction

  initial begin
    fail_count    = 0;
    pending       = 0;
    checked_count = 0;
    scroll_count  = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      cur_col = 0;
      cur_row = 0;
      hw_pos  = 0;
      attr    = ATTR_RESET;
      due_reports.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) attr = cfg_ch.data;
      if (in_ch.valid && in_ch.ready)
        due_reports.push_back(advance_console(in_ch.func, in_ch.char_code, in_ch.new_col,
                                              in_ch.new_row, in_ch.cell_addr));
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.cursor_col, out_ch.cursor_row, out_ch.hw_cursor_pos, out_ch.cell_data};
        if (due_reports.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("error: result with nothing due: col %0d row %0d hw %0d cell %h",
                     got.col, got.row, got.hw, got.data);
        end else begin
          want = due_reports.pop_front();
          checked_count++;
          if (got.col !== want.col || got.row !== want.row || got.hw !== want.hw ||
              got.data !== want.data) begin
            fail_count++;
            if (fail_count <= 10)
              $display("error: result %0d: exp col %0d row %0d hw %0d cell %h,",
                       checked_count, want.col, want.row, want.hw, want.data,
                       " got col %0d row %0d hw %0d cell %h",
                       got.col, got.row, got.hw, got.data);
          end
        end
      end
    end
    pending = due_reports.size();
  end

endmodule

// File: verif/tb_text_console_cursor_scroll.sv
// ----------------------------------------------------------------------------
// tb_text_console_cursor_scroll
// Drives directed and random console commands and attribute writes into the
// text console, with random command gaps and result stalls, a long result
// hold-off and a drain pause; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_text_console_cursor_scroll import tccs_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 4;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 200;

  logic clk = 1'b0;
  logic rst_n;
  logic no_gaps;
  logic hold_req;
  int   stall_left = 0;
  int   idle_cycles = 0;
  int   op_count [4] = '{0, 0, 0, 0};
  int   attr_writes = 0;
  int   fail_count, pending, checked_count, scroll_count;

  tccs_in_if  in_if ();
  tccs_out_if out_if ();
  tccs_cfg_if cfg_if ();

  text_console_cursor_scroll dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .out_if(out_if),
    .cfg_if(cfg_if)
  );

  tccs_console_checker console_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_if),
    .out_ch       (out_if),
    .cfg_ch       (cfg_if),
    .fail_count   (fail_count),
    .pending      (pending),
    .checked_count(checked_count),
    .scroll_count (scroll_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int gap_len();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_cmd(input logic [FUNC_W-1:0] f, input logic [CHAR_W-1:0] ch,
                          input logic [COL_W-1:0] c, input logic [ROW_W-1:0] r,
                          input logic [ADDR_W-1:0] a);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.func      <= f;
    in_if.char_code <= ch;
    in_if.new_col   <= c;
    in_if.new_row   <= r;
    in_if.cell_addr <= a;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    op_count[f]++;
    @(negedge clk);
  endtask

  task automatic put_char(input logic [CHAR_W-1:0] ch);
    send_cmd(FUNC_PUT, ch, COL_W'($urandom), ROW_W'($urandom), ADDR_W'($urandom));
  endtask

  task automatic move_cursor(input logic [COL_W-1:0] c, input logic [ROW_W-1:0] r);
    send_cmd(FUNC_SET, CHAR_W'($urandom), c, r, ADDR_W'($urandom));
  endtask

  task automatic read_cell(input logic [ADDR_W-1:0] a);
    send_cmd(FUNC_READ, CHAR_W'($urandom), COL_W'($urandom), ROW_W'($urandom), a);
  endtask

  task automatic clear_screen();
    send_cmd(FUNC_CLEAR, CHAR_W'($urandom), COL_W'($urandom), ROW_W'($urandom),
             ADDR_W'($urandom));
  endtask

  task automatic write_attr(input logic [ATTR_W-1:0] value);
    in_if.valid <= 1'b0;
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    attr_writes++;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic random_cmd();
    int r;
    logic [CHAR_W-1:0] ch;
    r = $urandom_range(99);
    if (r < 2) begin
      clear_screen();
    end else if (r < 16) begin
      move_cursor($urandom_range(99) < 30 ? COL_W'($urandom_range(70, 127))
                                          : COL_W'($urandom_range(0, 127)),
                  $urandom_range(99) < 50 ? ROW_W'($urandom_range(24, 31))
                                          : ROW_W'($urandom_range(0, 31)));
    end else if (r < 30) begin
      read_cell($urandom_range(99) < 10 ? ADDR_W'($urandom_range(CELLS, 2047))
                                        : ADDR_W'($urandom_range(0, CELLS - 1)));
    end else begin
      r = $urandom_range(99);
      if (r < 6)       ch = CH_NEWLINE;
      else if (r < 9)  ch = CH_RETURN;
      else if (r < 13) ch = CH_BACKSPACE;
      else if (r < 17) ch = CHAR_W'($urandom);
      else             ch = CHAR_W'($urandom_range(8'h20, 8'h7E));
      put_char(ch);
    end
  endtask

  // result side back-pressure
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(99) < 20) begin
        stall_left = gap_len();
        out_if.ready <= (stall_left == 0);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
    $display("tb_text_console_cursor_scroll failed");
    $finish;
  end

  initial begin
    in_if.valid     = 1'b0;
    in_if.func      = FUNC_PUT;
    in_if.char_code = '0;
    in_if.new_col   = '0;
    in_if.new_row   = '0;
    in_if.cell_addr = '0;
    cfg_if.valid    = 1'b0;
    cfg_if.data     = '0;
    rst_n           = 1'b0;
    no_gaps         = 1'b0;
    hold_req        = 1'b0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // directed part, reset attribute
    clear_screen();
    read_cell(11'd0);
    put_char(8'h41);
    put_char(8'h00);
    put_char(8'hFF);
    repeat (4) put_char(CH_BACKSPACE);
    put_char(CH_NEWLINE);
    put_char(8'h7E);
    put_char(CH_RETURN);
    move_cursor(7'd127, 5'd31);
    put_char(8'h5A);
    read_cell(11'd1919);
    read_cell(11'd1999);
    move_cursor(7'd0, 5'd0);
    move_cursor(7'd78, 5'd24);
    put_char(8'h71);
    move_cursor(7'd5, 5'd24);
    put_char(CH_NEWLINE);
    read_cell(11'd2047);
    read_cell(11'd2000);
    move_cursor(7'd3, 5'd10);
    clear_screen();
    read_cell(11'd1999);

    for (int p = 0; p < PHASES; p++) begin
      write_attr(p == 0 ? 8'h00 : p == 1 ? 8'hFF : p == PHASES - 1 ? ATTR_RESET
                                                     : ATTR_W'($urandom));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        no_gaps = (p % 2 == 1) && (i < 40);
        if (p == 2 && i == 60) hold_req = 1'b1;
        if (p == 4 && i == 100) begin
          in_if.valid <= 1'b0;
          wait (pending == 0);
          @(negedge clk);
        end
        random_cmd();
      end
    end

    in_if.valid <= 1'b0;
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("summary: put %0d, clear %0d, set cursor %0d, read %0d; %0d results checked",
             op_count[FUNC_PUT], op_count[FUNC_CLEAR], op_count[FUNC_SET],
             op_count[FUNC_READ], checked_count);
    $display("summary: %0d scrolls, %0d attribute writes, %0d failures",
             scroll_count, attr_writes, fail_count);
    if (fail_count == 0 && pending == 0)
      $display("tb_text_console_cursor_scroll passed");
    else
      $display("tb_text_console_cursor_scroll failed");
    $finish;
  end

endmodule
